// ===== hw/rtl/delay_slot_timer_pool_unit_assert.svh =====
// ---------------------------------------------------------------------------
// delay_slot_timer_pool_unit assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef DELAY_SLOT_TIMER_POOL_UNIT_ASSERT_SVH
`define DELAY_SLOT_TIMER_POOL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define DSTP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent follows the antecedent as a non-overlapping implication
`define DSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DSTP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/dstp_pkg.sv =====
// ---------------------------------------------------------------------------
// dstp_pkg
// shared types and codes of the delay slot timer pool
// ---------------------------------------------------------------------------
package dstp_pkg;

    localparam int TAG_W  = 8;
    localparam int SLOT_W = 3;

    // command field codes
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef enum logic [1:0] {
        KIND_SCHEDULED = 2'd0,
        KIND_FULL      = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_TICK_DONE = 2'd3
    } t_kind;

endpackage

// ===== hw/rtl/dstp_cell.sv =====
// ---------------------------------------------------------------------------
// dstp_cell
// one timer slot of the ring: holds count and tag, passes them on when shifted
// ---------------------------------------------------------------------------
module dstp_cell #(
    parameter int DELAY_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [DELAY_BITS-1:0]         i_count,
    input  logic [dstp_pkg::TAG_W-1:0]    i_tag,
    output logic [DELAY_BITS-1:0]         o_count,
    output logic [dstp_pkg::TAG_W-1:0]    o_tag
);

    logic [DELAY_BITS-1:0]      r_count;
    logic [dstp_pkg::TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_shift) begin
            r_count <= i_count;
        end
    end

    // tag is only read once its slot has been loaded
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag <= i_tag;
        end
    end

    assign o_count = r_count;
    assign o_tag   = r_tag;

endmodule

// ===== hw/rtl/delay_slot_timer_pool_unit.sv =====
// ---------------------------------------------------------------------------
// delay_slot_timer_pool_unit
// pool of one-shot countdown timers, kept in a rotating ring of slot cells
// ---------------------------------------------------------------------------
// Each item is accepted in ST_IDLE; in ST_SWEEP the slot ring then rotates
// one place per cycle unless an expiry beat is stalled, so every slot passes
// the head cell once in slot order (back in place at the end); then ST_FINAL
// issues the final beat. A single output register carries results; while it
// is stalled the ring holds on any slot that would expire, so each expiry
// beat adds the stall time on top, and the final beat waits in the same way.
// A new item is taken once the previous one has issued its final beat, even
// if that beat is still waiting at the output.
// ---------------------------------------------------------------------------
`include "delay_slot_timer_pool_unit_assert.svh"

module delay_slot_timer_pool_unit #(
    parameter int SLOTS      = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [15:0]                   i_delay,
    input  logic [7:0]                    i_action_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [2:0]                    o_slot,
    output logic [7:0]                    o_expired_tag,
    output logic                          o_timer_running,
    output logic                          o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FINAL = 3'b100
    } t_state;

    logic [DELAY_BITS-1:0]      w_count [SLOTS];
    logic [dstp_pkg::TAG_W-1:0] w_tag   [SLOTS];

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_found, n_found;
    logic [IDX_W-1:0]           r_found_idx, n_found_idx;
    logic                       r_active, n_active;
    logic                       r_running, n_running;

    logic                       r_cmd;
    logic [DELAY_BITS-1:0]      r_delay;
    logic [dstp_pkg::TAG_W-1:0] r_tag_in;

    logic                       r_out_valid, n_out_valid;
    dstp_pkg::t_kind            r_kind, n_kind;
    logic [dstp_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [dstp_pkg::TAG_W-1:0] r_etag, n_etag;
    logic                       r_run_out, n_run_out;
    logic                       r_last, n_last;

    logic                       w_shift;
    logic [DELAY_BITS-1:0]      w_head_count;
    logic [dstp_pkg::TAG_W-1:0] w_head_tag;
    logic                       w_in_accept;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_step;

    // ring of slot cells, head is cell 0 and feeds the tail through the update
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == SLOTS - 1) begin : g_tail
            dstp_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_count (w_head_count),
                .i_tag   (w_head_tag),
                .o_count (w_count[k]),
                .o_tag   (w_tag[k])
            );
        end else begin : g_mid
            dstp_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_count (w_count[k+1]),
                .i_tag   (w_tag[k+1]),
                .o_count (w_count[k]),
                .o_tag   (w_tag[k])
            );
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_cmd == dstp_pkg::CMD_TICK) && (w_count[0] == DELAY_BITS'(1));
    assign w_step      = (r_state == ST_SWEEP) && (!w_emit || w_out_free);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_active     = r_active;
        n_running    = r_running;
        n_out_valid  = r_out_valid && i_out_stall;
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_etag       = r_etag;
        n_run_out    = r_run_out;
        n_last       = r_last;
        w_shift      = 1'b0;
        w_head_count = w_count[0];
        w_head_tag   = w_tag[0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_SWEEP;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_active = 1'b0;
                end
            end
            ST_SWEEP: begin
                if (w_step) begin
                    w_shift = 1'b1;
                    if (r_cmd == dstp_pkg::CMD_TICK) begin
                        if (w_count[0] != '0) begin
                            w_head_count = w_count[0] - DELAY_BITS'(1);
                            n_active     = 1'b1;
                            if (w_emit) begin
                                n_out_valid = 1'b1;
                                n_kind      = dstp_pkg::KIND_EXPIRED;
                                n_slot      = dstp_pkg::SLOT_W'(r_idx);
                                n_etag      = w_tag[0];
                                n_run_out   = r_running;
                                n_last      = 1'b0;
                            end
                        end
                    end else if (!r_found && (w_count[0] == '0)) begin
                        // first free slot in order takes the new timer
                        w_head_count = r_delay;
                        w_head_tag   = r_tag_in;
                        n_found      = 1'b1;
                        n_found_idx  = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FINAL;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_etag      = '0;
                    n_state     = ST_IDLE;
                    if (r_cmd == dstp_pkg::CMD_TICK) begin
                        n_running = r_active && r_running;
                        n_kind    = dstp_pkg::KIND_TICK_DONE;
                        n_slot    = '0;
                        n_run_out = r_active && r_running;
                    end else if (r_found) begin
                        n_running = 1'b1;
                        n_kind    = dstp_pkg::KIND_SCHEDULED;
                        n_slot    = dstp_pkg::SLOT_W'(r_found_idx);
                        n_run_out = 1'b1;
                    end else begin
                        n_kind    = dstp_pkg::KIND_FULL;
                        n_slot    = '0;
                        n_run_out = r_running;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_active    <= 1'b0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_found_idx <= n_found_idx;
            r_active    <= n_active;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    // input beat and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd    <= i_cmd;
            r_delay  <= DELAY_BITS'(i_delay);
            r_tag_in <= i_action_tag;
        end
        r_kind    <= n_kind;
        r_slot    <= n_slot;
        r_etag    <= n_etag;
        r_run_out <= n_run_out;
        r_last    <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_slot          = r_slot;
    assign o_expired_tag   = r_etag;
    assign o_timer_running = r_run_out;
    assign o_last          = r_last;

    `DSTP_ASSERT_ALWAYS(a_idx_zero_idle, i_clk, i_rst_n, (r_state != ST_IDLE) || (r_idx == '0))
    `DSTP_ASSERT_NEXT(a_accept_sweeps, i_clk, i_rst_n, w_in_accept, r_state == ST_SWEEP)
    `DSTP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_kind) && $stable(r_slot))
    `DSTP_ASSERT_ALWAYS(a_expiry_not_last, i_clk, i_rst_n,
        !r_out_valid || (r_kind != dstp_pkg::KIND_EXPIRED) || !r_last)
    `DSTP_ASSERT_ALWAYS(a_ring_still_idle, i_clk, i_rst_n, !w_shift || (r_state == ST_SWEEP))

endmodule
